FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the panel controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while reset is high.
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every clock edge.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/sspc_pkg.sv
// ----------------------------------------------------------------------------
// sspc_pkg
// Types and constants shared by the step sequencer panel controller.
// ----------------------------------------------------------------------------
package sspc_pkg;

   localparam int TRACKS_DEFAULT         = 8;
   localparam int AVERAGE_LENGTH_DEFAULT = 8;

   typedef enum logic [2:0] {
      CMD_SWITCH     = 3'd0,
      CMD_EXPIRY     = 3'd1,
      CMD_ENCODER    = 3'd2,
      CMD_POT        = 3'd3,
      CMD_READ_START = 3'd4,
      CMD_READ_NEXT  = 3'd5,
      CMD_WRITE      = 3'd6
   } cmd_code_type;

   // Quadrature history codes after a valid transition.
   localparam logic [3:0] ENC_UP_A   = 4'b0001;
   localparam logic [3:0] ENC_UP_B   = 4'b1110;
   localparam logic [3:0] ENC_DOWN_A = 4'b0010;
   localparam logic [3:0] ENC_DOWN_B = 4'b1101;

   // Change flag bit positions.
   localparam int FLAG_TRACK = 1;
   localparam int FLAG_PLAY  = 2;
   localparam int FLAG_LOWER = 3;
   localparam int FLAG_UPPER = 4;
   localparam int FLAG_POT0  = 5;
   localparam int FLAG_POT1  = 6;

   // Snapshot byte positions.
   localparam int SNAP_FLAGS   = 0;
   localparam int SNAP_TRACK   = 1;
   localparam int SNAP_PLAYING = 2;
   localparam int SNAP_LOWER   = 3;
   localparam int SNAP_UPPER   = 4;
   localparam int SNAP_POT0    = 5;
   localparam int SNAP_POT1    = 6;
   localparam int SNAP_BYTES   = 7;

   // One strobe per command, already gated by the transfer and the halt.
   typedef struct packed {
      logic sw_change;
      logic expiry;
      logic encoder;
      logic pot;
      logic read_start;
      logic read_next;
      logic write;
   } cmd_strobe_type;

   typedef struct packed {
      logic [2:0]  track;
      logic        upper_side;
      logic        stopped;
      logic [15:0] row;        // upper pattern in [15:8], lower in [7:0]
   } panel_status_type;

   typedef struct packed {
      logic track_moved;
      logic play_toggled;
      logic lower_changed;
      logic upper_changed;
   } panel_flags_type;

endpackage

FILE: rtl/step_sequencer_panel_controller_top.sv
// ----------------------------------------------------------------------------
// step_sequencer_panel_controller_top
// Front-panel controller for a step sequencer, read out by a bus master.
// ----------------------------------------------------------------------------
//   Channel | Direction | Handshake           | Payload
//   req_    | in        | req_valid/req_stall | command and panel samples
//   rsp_    | out       | rsp_valid/rsp_stall | read byte, LEDs, bus error
//
// Each command passes through the input register and one state update, so
// one transfer per clock is sustained while the result is not stalled; the input
// register and the result register let an item be taken while a result waits.
// Reset is synchronous and clears all panel, averaging and snapshot state.
// While a result is stalled the input register holds one more item and then
// stalls; the LED outputs show the state left by the item being delivered.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module step_sequencer_panel_controller_top #(
   parameter int TRACKS         = sspc_pkg::TRACKS_DEFAULT,
   parameter int AVERAGE_LENGTH = sspc_pkg::AVERAGE_LENGTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_command,
   input  logic [7:0] req_step_switches,
   input  logic       req_side_switch,
   input  logic       req_play_switch,
   input  logic [1:0] req_encoder_ab,
   input  logic [1:0] req_encoder_ab_again,
   input  logic [7:0] req_pot_raw,
   input  logic [7:0] req_bus_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data,
   output logic [7:0] rsp_step_leds,
   output logic       rsp_upper_side_led,
   output logic       rsp_stopped_led,
   output logic       rsp_bus_error
);
   import sspc_pkg::*;

   logic       s1_valid_ff;
   logic [2:0] s1_command_ff;
   logic [7:0] s1_steps_ff;
   logic       s1_side_ff;
   logic       s1_play_ff;
   logic [1:0] s1_enc_ff;
   logic [1:0] s1_enc_again_ff;
   logic [7:0] s1_pot_ff;
   logic [7:0] s1_byte_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   logic             advance;
   logic             execute;
   logic             req_take;
   cmd_strobe_type   strobe;
   panel_status_type status;
   panel_flags_type  flags_set;
   logic [1:0][3:0]  pot_levels;
   logic [7:0]       bus_read_data;
   logic             halted;
   logic [7:0]       playing_note;
   logic [7:0]       rsp_data_in;
   logic [7:0]       marker;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign execute   = advance && !halted;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      strobe = '0;
      if (execute) begin
         unique case (s1_command_ff)
            CMD_SWITCH:     strobe.sw_change  = 1'b1;
            CMD_EXPIRY:     strobe.expiry     = 1'b1;
            CMD_ENCODER:    strobe.encoder    = 1'b1;
            CMD_POT:        strobe.pot        = 1'b1;
            CMD_READ_START: strobe.read_start = 1'b1;
            CMD_READ_NEXT:  strobe.read_next  = 1'b1;
            CMD_WRITE:      strobe.write      = 1'b1;
            default:        strobe            = '0;
         endcase
      end
   end

   sspc_panel #(
      .TRACKS(TRACKS)
   ) u_panel (
      .clock            (clock),
      .reset            (reset),
      .strobe           (strobe),
      .step_switches    (s1_steps_ff),
      .side_switch      (s1_side_ff),
      .play_switch      (s1_play_ff),
      .encoder_ab       (s1_enc_ff),
      .encoder_ab_again (s1_enc_again_ff),
      .status           (status),
      .flags_set        (flags_set)
   );

   sspc_pot #(
      .AVERAGE_LENGTH(AVERAGE_LENGTH)
   ) u_pot (
      .clock      (clock),
      .reset      (reset),
      .strobe     (strobe),
      .pot_raw    (s1_pot_ff),
      .pot_levels (pot_levels)
   );

   sspc_bus u_bus (
      .clock        (clock),
      .reset        (reset),
      .strobe       (strobe),
      .status       (status),
      .flags_set    (flags_set),
      .pot_levels   (pot_levels),
      .bus_byte     (s1_byte_ff),
      .read_data    (bus_read_data),
      .halted       (halted),
      .playing_note (playing_note)
   );

   assign rsp_data_in = execute ? bus_read_data : 8'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (advance) begin
            s1_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_take) begin
         s1_command_ff   <= req_command;
         s1_steps_ff     <= req_step_switches;
         s1_side_ff      <= req_side_switch;
         s1_play_ff      <= req_play_switch;
         s1_enc_ff       <= req_encoder_ab;
         s1_enc_again_ff <= req_encoder_ab_again;
         s1_pot_ff       <= req_pot_raw;
         s1_byte_ff      <= req_bus_byte;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // The playing note lights one step on the side it belongs to while running.
   always_comb begin
      marker = 8'd0;
      if (!status.stopped) begin
         if ((!status.upper_side && playing_note[7:3] == 5'd0)
             || (status.upper_side && playing_note[7:3] == 5'd1)) begin
            marker = 8'd1 << playing_note[2:0];
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_read_data      = rsp_data_ff;
   assign rsp_step_leds      = (status.upper_side ? status.row[15:8] : status.row[7:0])
                               | marker;
   assign rsp_upper_side_led = status.upper_side;
   assign rsp_stopped_led    = status.stopped;
   assign rsp_bus_error      = halted;

   `ASSERT_RST(a_halt_sticky, clock, reset,
      rsp_bus_error |=> rsp_bus_error,
      "bus error cleared without reset")
   `ASSERT_RST(a_data_only_on_read, clock, reset,
      (rsp_data_in != 8'd0) |-> (strobe.read_start || strobe.read_next),
      "nonzero read byte from a command that is not a read")
   `ASSERT_RST(a_result_from_item, clock, reset,
      $rose(rsp_valid_ff) |-> $past(advance),
      "result appeared without an item leaving the input register")
   `ASSERT_RST(a_halt_blocks, clock, reset,
      halted |-> (strobe == '0),
      "command executed while halted")

endmodule

FILE: rtl/sspc_pot.sv
// ----------------------------------------------------------------------------
// sspc_pot
// Two-channel potentiometer block averager with alternating channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sspc_pot #(
   parameter int AVERAGE_LENGTH = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  sspc_pkg::cmd_strobe_type strobe,
   input  logic [7:0]               pot_raw,
   output logic [1:0][3:0]          pot_levels
);
   import sspc_pkg::*;

   localparam int SUM_W       = $clog2(15 * AVERAGE_LENGTH + 1);
   localparam int CNT_W       = $clog2(AVERAGE_LENGTH + 1);
   localparam int RECIP_SHIFT = 16;
   localparam logic [16:0] RECIP =
      17'((2 ** RECIP_SHIFT + AVERAGE_LENGTH - 1) / AVERAGE_LENGTH);
   localparam int PROD_W = SUM_W + 17;

   logic [SUM_W-1:0] sum_ff [2];
   logic [CNT_W-1:0] count_ff [2];
   logic [3:0]       level_ff [2];
   logic             channel_ff;

   logic [SUM_W-1:0]  sum_in;
   logic [CNT_W-1:0]  count_in;
   logic              block_done;
   logic [PROD_W-1:0] product;
   logic [3:0]        level_in;

   always_comb begin
      sum_in     = sum_ff[channel_ff] + SUM_W'(pot_raw[7:4]);
      count_in   = count_ff[channel_ff] + CNT_W'(1);
      block_done = count_in >= CNT_W'(AVERAGE_LENGTH);
      // Division by the block length as a reciprocal multiply, exact for these sums.
      product    = PROD_W'(sum_in) * PROD_W'(RECIP);
      level_in   = product[RECIP_SHIFT +: 4];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            sum_ff[i]   <= '0;
            count_ff[i] <= '0;
            level_ff[i] <= '0;
         end
         channel_ff <= 1'b0;
      end else if (strobe.pot) begin
         if (block_done) begin
            level_ff[channel_ff] <= level_in;
            sum_ff[channel_ff]   <= '0;
            count_ff[channel_ff] <= '0;
         end else begin
            sum_ff[channel_ff]   <= sum_in;
            count_ff[channel_ff] <= count_in;
         end
         channel_ff <= ~channel_ff;
      end
   end

   assign pot_levels[0] = level_ff[0];
   assign pot_levels[1] = level_ff[1];

   `ASSERT_RST(a_count_range, clock, reset,
      (count_ff[0] < CNT_W'(AVERAGE_LENGTH)) && (count_ff[1] < CNT_W'(AVERAGE_LENGTH)),
      "pot sample count reached the block length")

endmodule

FILE: rtl/sspc_panel.sv
// ----------------------------------------------------------------------------
// sspc_panel
// Switch debounce, step patterns, side and play state, encoder track select.
// ----------------------------------------------------------------------------
module sspc_panel #(
   parameter int TRACKS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  sspc_pkg::cmd_strobe_type   strobe,
   input  logic [7:0]                 step_switches,
   input  logic                       side_switch,
   input  logic                       play_switch,
   input  logic [1:0]                 encoder_ab,
   input  logic [1:0]                 encoder_ab_again,
   output sspc_pkg::panel_status_type status,
   output sspc_pkg::panel_flags_type  flags_set
);
   import sspc_pkg::*;

   localparam int IDX_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
   localparam logic [2:0] TRACK_MAX = 3'(TRACKS - 1);

   logic [15:0] rows_ff [TRACKS];
   logic        upper_ff;
   logic        stopped_ff;
   logic [2:0]  track_ff;
   logic [3:0]  history_ff;
   logic [7:0]  cap_steps_ff;
   logic        cap_side_ff;
   logic        cap_play_ff;
   logic        pending_ff;

   logic [IDX_W-1:0] idx;
   logic [15:0]      row;
   logic             do_expiry;
   logic             upper_in;
   logic             stopped_in;
   logic [15:0]      row_in;
   logic [7:0]       half_old;
   logic             steps_hit;
   logic             samples_agree;
   logic [3:0]       history_in;
   logic [2:0]       track_in;

   assign idx = track_ff[IDX_W-1:0];
   assign row = rows_ff[idx];

   always_comb begin
      do_expiry = strobe.expiry && pending_ff;

      // The side toggles first; the pattern toggle lands on the new side.
      upper_in = upper_ff;
      if (cap_side_ff == side_switch) begin
         upper_in = upper_ff ^ cap_side_ff;
      end
      half_old  = upper_in ? row[15:8] : row[7:0];
      steps_hit = cap_steps_ff == step_switches;
      row_in    = row;
      if (steps_hit) begin
         if (upper_in) begin
            row_in[15:8] = half_old ^ cap_steps_ff;
         end else begin
            row_in[7:0] = half_old ^ cap_steps_ff;
         end
      end
      stopped_in = stopped_ff;
      if (cap_play_ff == play_switch) begin
         stopped_in = stopped_ff ^ cap_play_ff;
      end

      samples_agree = encoder_ab == encoder_ab_again;
      history_in    = {history_ff[1:0], encoder_ab};
      track_in      = track_ff;
      if (samples_agree) begin
         if (history_in == ENC_UP_A || history_in == ENC_UP_B) begin
            if (track_ff < TRACK_MAX) begin
               track_in = track_ff + 3'd1;
            end
         end else if (history_in == ENC_DOWN_A || history_in == ENC_DOWN_B) begin
            if (track_ff != 3'd0) begin
               track_in = track_ff - 3'd1;
            end
         end
      end

      flags_set.track_moved   = strobe.encoder && (track_in != track_ff);
      flags_set.play_toggled  = do_expiry && (stopped_in != stopped_ff);
      flags_set.lower_changed = do_expiry && steps_hit && !upper_in
                                && (cap_steps_ff != 8'd0);
      flags_set.upper_changed = do_expiry && steps_hit && upper_in
                                && (cap_steps_ff != 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TRACKS; i++) begin
            rows_ff[i] <= '0;
         end
         upper_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
         track_ff     <= '0;
         history_ff   <= '0;
         cap_steps_ff <= '0;
         cap_side_ff  <= 1'b0;
         cap_play_ff  <= 1'b0;
         pending_ff   <= 1'b0;
      end else begin
         if (strobe.sw_change && !pending_ff) begin
            cap_steps_ff <= step_switches;
            cap_side_ff  <= side_switch;
            cap_play_ff  <= play_switch;
            pending_ff   <= 1'b1;
         end
         if (do_expiry) begin
            upper_ff     <= upper_in;
            stopped_ff   <= stopped_in;
            rows_ff[idx] <= row_in;
            pending_ff   <= 1'b0;
         end
         if (strobe.encoder) begin
            track_ff <= track_in;
            if (samples_agree) begin
               history_ff <= history_in;
            end
         end
      end
   end

   assign status.track      = track_ff;
   assign status.upper_side = upper_ff;
   assign status.stopped    = stopped_ff;
   assign status.row        = row;

endmodule

FILE: rtl/sspc_bus.sv
// ----------------------------------------------------------------------------
// sspc_bus
// Change flags, read snapshot, read pointer, halt and playing note register.
// ----------------------------------------------------------------------------
module sspc_bus (
   input  logic                       clock,
   input  logic                       reset,
   input  sspc_pkg::cmd_strobe_type   strobe,
   input  sspc_pkg::panel_status_type status,
   input  sspc_pkg::panel_flags_type  flags_set,
   input  logic [1:0][3:0]            pot_levels,
   input  logic [7:0]                 bus_byte,
   output logic [7:0]                 read_data,
   output logic                       halted,
   output logic [7:0]                 playing_note
);
   import sspc_pkg::*;

   logic [7:0] flags_ff;
   logic [3:0] reported_ff [2];
   logic [7:0] snap_ff [SNAP_BYTES];
   logic [2:0] pos_ff;
   logic       halted_ff;
   logic [7:0] note_ff;

   logic [7:0] flags_now;
   logic [7:0] flags_in;
   logic [7:0] snap_flags;
   logic       past_end;

   always_comb begin
      flags_now = flags_ff;
      flags_now[FLAG_TRACK] = flags_ff[FLAG_TRACK] | flags_set.track_moved;
      flags_now[FLAG_PLAY]  = flags_ff[FLAG_PLAY]  | flags_set.play_toggled;
      flags_now[FLAG_LOWER] = flags_ff[FLAG_LOWER] | flags_set.lower_changed;
      flags_now[FLAG_UPPER] = flags_ff[FLAG_UPPER] | flags_set.upper_changed;

      snap_flags = flags_ff;
      snap_flags[FLAG_POT0] = flags_ff[FLAG_POT0] | (pot_levels[0] != reported_ff[0]);
      snap_flags[FLAG_POT1] = flags_ff[FLAG_POT1] | (pot_levels[1] != reported_ff[1]);

      flags_in = strobe.read_start ? 8'd0 : flags_now;
      past_end = pos_ff >= 3'(SNAP_BYTES);

      read_data = 8'd0;
      if (strobe.read_start) begin
         read_data = snap_flags;
      end else if (strobe.read_next && !past_end) begin
         read_data = snap_ff[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff       <= '0;
         reported_ff[0] <= '0;
         reported_ff[1] <= '0;
         for (int i = 0; i < SNAP_BYTES; i++) begin
            snap_ff[i] <= '0;
         end
         pos_ff    <= '0;
         halted_ff <= 1'b0;
         note_ff   <= '0;
      end else begin
         flags_ff <= flags_in;
         if (strobe.read_start) begin
            reported_ff[0]       <= pot_levels[0];
            reported_ff[1]       <= pot_levels[1];
            snap_ff[SNAP_FLAGS]   <= snap_flags;
            snap_ff[SNAP_TRACK]   <= {5'd0, status.track};
            snap_ff[SNAP_PLAYING] <= {7'd0, !status.stopped};
            snap_ff[SNAP_LOWER]   <= status.row[7:0];
            snap_ff[SNAP_UPPER]   <= status.row[15:8];
            snap_ff[SNAP_POT0]    <= {4'd0, pot_levels[0]};
            snap_ff[SNAP_POT1]    <= {4'd0, pot_levels[1]};
            pos_ff                <= 3'd1;
         end
         if (strobe.read_next) begin
            if (past_end) begin
               halted_ff <= 1'b1;
            end else begin
               pos_ff <= pos_ff + 3'd1;
            end
         end
         if (strobe.write) begin
            note_ff <= bus_byte;
         end
      end
   end

   assign halted       = halted_ff;
   assign playing_note = note_ff;

endmodule

FILE: dv/step_sequencer_panel_controller_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_panel_controller_top_test
// Drives panel events into the step sequencer front-panel controller and
// compares every result with a cycle-free model of the panel state: switch
// debounce and toggles, encoder track moves with limits, pot averaging,
// snapshot reads, the playing-note marker and the halt after an overrun.
// ----------------------------------------------------------------------------
module step_sequencer_panel_controller_top_test;
   import sspc_pkg::*;

   localparam logic [2:0] CMD_SPARE    = 3'd7;
   localparam int         RANDOM_ITEMS = 900;
   localparam int         LONG_HOLD    = 64;
   localparam int         DRAIN_CYCLES = 20;
   localparam int         RUN_LIMIT_NS = 4_000_000;

   typedef struct {
      bit [2:0] command;
      bit [7:0] steps;
      bit       side;
      bit       play;
      bit [1:0] enc_a;
      bit [1:0] enc_b;
      bit [7:0] pot_raw;
      bit [7:0] note;
   } panel_event_type;

   typedef struct {
      logic [7:0] read_data;
      logic [7:0] step_leds;
      logic       upper_side_led;
      logic       stopped_led;
      logic       bus_error;
   } led_readout_type;

   class panel_scoreboard;
      bit [7:0]        patterns [16];
      bit              upper_side, stopped, pending, cap_side, cap_play, pot_channel, halted;
      bit [2:0]        track, read_pos;
      bit [3:0]        enc_history;
      bit [7:0]        cap_steps, flags, note;
      bit [7:0]        snapshot [SNAP_BYTES];
      int              pot_sum [2];
      int              pot_count [2];
      bit [3:0]        pot_level [2];
      bit [3:0]        reported_level [2];
      led_readout_type readouts_due [$];
      int              mismatches, compared, clamp_hits;
      int              seen [8];

      task report_mismatch(string what, int got, int want);
         mismatches++;
         $display("[%0t] result %0d: %s got 'h%0h, want 'h%0h", $time, compared, what, got,
                  want);
      endtask

      function led_readout_type update_panel(panel_event_type ev);
         led_readout_type res;
         bit [3:0]        idx;
         bit [7:0]        old_row, marker, rd;
         bit              old_stop;
         bit [2:0]        p;
         int              pos, c;
         rd = 8'd0;
         marker = 8'd0;
         if (!halted) begin
            case (ev.command)
               CMD_SWITCH: if (!pending) begin
                  cap_steps = ev.steps;
                  cap_side = ev.side;
                  cap_play = ev.play;
                  pending = 1'b1;
               end
               CMD_EXPIRY: if (pending) begin
                  // The side flips first, so the pattern toggle lands on the new side.
                  if (cap_side == ev.side) upper_side ^= cap_side;
                  if (cap_steps == ev.steps) begin
                     idx = {track, upper_side};
                     old_row = patterns[idx];
                     patterns[idx] = old_row ^ cap_steps;
                     if (patterns[idx] != old_row)
                        flags[upper_side ? FLAG_UPPER : FLAG_LOWER] = 1'b1;
                  end
                  if (cap_play == ev.play) begin
                     old_stop = stopped;
                     stopped ^= cap_play;
                     if (stopped != old_stop) flags[FLAG_PLAY] = 1'b1;
                  end
                  pending = 1'b0;
               end
               CMD_ENCODER: if (ev.enc_a == ev.enc_b) begin
                  enc_history = {enc_history[1:0], ev.enc_a};
                  pos = int'(track);
                  if (enc_history == ENC_UP_A || enc_history == ENC_UP_B) pos++;
                  else if (enc_history == ENC_DOWN_A || enc_history == ENC_DOWN_B) pos--;
                  if (pos < 0 || pos >= TRACKS_DEFAULT) clamp_hits++;
                  if (pos < 0) pos = 0;
                  if (pos >= TRACKS_DEFAULT) pos = TRACKS_DEFAULT - 1;
                  if (pos != int'(track)) flags[FLAG_TRACK] = 1'b1;
                  track = 3'(pos);
               end
               CMD_POT: begin
                  c = int'(pot_channel);
                  pot_sum[c] += int'(ev.pot_raw[7:4]);
                  pot_count[c]++;
                  if (pot_count[c] >= AVERAGE_LENGTH_DEFAULT) begin
                     pot_level[c] = 4'(pot_sum[c] / AVERAGE_LENGTH_DEFAULT);
                     pot_sum[c] = 0;
                     pot_count[c] = 0;
                  end
                  pot_channel = ~pot_channel;
               end
               CMD_READ_START: begin
                  for (int i = 0; i < 2; i++) begin
                     if (pot_level[i] != reported_level[i]) begin
                        reported_level[i] = pot_level[i];
                        flags[FLAG_POT0 + i] = 1'b1;
                     end
                  end
                  snapshot[SNAP_FLAGS] = flags;
                  snapshot[SNAP_TRACK] = {5'd0, track};
                  snapshot[SNAP_PLAYING] = stopped ? 8'd0 : 8'd1;
                  snapshot[SNAP_LOWER] = patterns[{track, 1'b0}];
                  snapshot[SNAP_UPPER] = patterns[{track, 1'b1}];
                  snapshot[SNAP_POT0] = {4'd0, pot_level[0]};
                  snapshot[SNAP_POT1] = {4'd0, pot_level[1]};
                  flags = 8'd0;
                  read_pos = 3'd1;
                  rd = snapshot[SNAP_FLAGS];
               end
               CMD_READ_NEXT: begin
                  p = read_pos;
                  if (int'(p) >= SNAP_BYTES) halted = 1'b1;
                  else begin
                     read_pos = p + 3'd1;
                     rd = snapshot[p];
                  end
               end
               CMD_WRITE: note = ev.note;
               default: ;
            endcase
         end
         if (!stopped) begin
            if (!upper_side && note < 8'd8) marker = 8'd1 << note[2:0];
            else if (upper_side && note >= 8'd8 && note < 8'd16) marker = 8'd1 << note[2:0];
         end
         res.read_data = rd;
         res.step_leds = patterns[{track, upper_side}] | marker;
         res.upper_side_led = upper_side;
         res.stopped_led = stopped;
         res.bus_error = halted;
         return res;
      endfunction

      function void note_command(panel_event_type ev);
         seen[ev.command]++;
         readouts_due.push_back(update_panel(ev));
      endfunction

      task check_readout(led_readout_type got);
         led_readout_type want;
         if (readouts_due.size() == 0) begin
            report_mismatch("result with nothing due, leds", int'(got.step_leds), 0);
            return;
         end
         want = readouts_due.pop_front();
         compared++;
         if (got.read_data !== want.read_data)
            report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
         if (got.step_leds !== want.step_leds)
            report_mismatch("step_leds", int'(got.step_leds), int'(want.step_leds));
         if (got.upper_side_led !== want.upper_side_led)
            report_mismatch("upper_side_led", int'(got.upper_side_led),
                            int'(want.upper_side_led));
         if (got.stopped_led !== want.stopped_led)
            report_mismatch("stopped_led", int'(got.stopped_led), int'(want.stopped_led));
         if (got.bus_error !== want.bus_error)
            report_mismatch("bus_error", int'(got.bus_error), int'(want.bus_error));
      endtask

      function int due_count();
         return readouts_due.size();
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [2:0] req_command;
   logic [7:0] req_step_switches;
   logic       req_side_switch;
   logic       req_play_switch;
   logic [1:0] req_encoder_ab;
   logic [1:0] req_encoder_ab_again;
   logic [7:0] req_pot_raw;
   logic [7:0] req_bus_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_read_data;
   logic [7:0] rsp_step_leds;
   logic       rsp_upper_side_led;
   logic       rsp_stopped_led;
   logic       rsp_bus_error;

   panel_scoreboard sb;
   int              read_pos;
   int              send_burst;
   int              events_sent;
   bit              halt_wanted;
   bit [1:0]        enc_phase;

   step_sequencer_panel_controller_top u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_step_switches   (req_step_switches),
      .req_side_switch     (req_side_switch),
      .req_play_switch     (req_play_switch),
      .req_encoder_ab      (req_encoder_ab),
      .req_encoder_ab_again(req_encoder_ab_again),
      .req_pot_raw         (req_pot_raw),
      .req_bus_byte        (req_bus_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_read_data       (rsp_read_data),
      .rsp_step_leds       (rsp_step_leds),
      .rsp_upper_side_led  (rsp_upper_side_led),
      .rsp_stopped_led     (rsp_stopped_led),
      .rsp_bus_error       (rsp_bus_error)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Idle cycles before an item; runs of back-to-back items come in bursts.
   function automatic int next_gap(inout int burst_left);
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 24) == 0) begin
         burst_left = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
   endfunction

   function automatic panel_event_type random_event(bit [2:0] command);
      panel_event_type ev;
      ev.command = command;
      ev.steps = 8'($urandom());
      ev.side = 1'($urandom());
      ev.play = 1'($urandom());
      ev.enc_a = 2'($urandom());
      ev.enc_b = 2'($urandom());
      ev.pot_raw = 8'($urandom());
      ev.note = 8'($urandom());
      return ev;
   endfunction

   task automatic send_event(panel_event_type ev);
      int gap;
      // Keep the read position inside the snapshot unless the overrun is wanted.
      if (ev.command == CMD_READ_NEXT && read_pos >= SNAP_BYTES && !halt_wanted)
         ev.command = CMD_READ_START;
      if (ev.command == CMD_READ_START) read_pos = 1;
      else if (ev.command == CMD_READ_NEXT && read_pos < SNAP_BYTES) read_pos++;
      gap = next_gap(send_burst);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_command <= ev.command;
      req_step_switches <= ev.steps;
      req_side_switch <= ev.side;
      req_play_switch <= ev.play;
      req_encoder_ab <= ev.enc_a;
      req_encoder_ab_again <= ev.enc_b;
      req_pot_raw <= ev.pot_raw;
      req_bus_byte <= ev.note;
      do @(posedge clock); while (req_stall !== 1'b0);
      events_sent++;
   endtask

   task automatic turn_encoder(bit up, bit garble);
      panel_event_type ev;
      enc_phase = up ? enc_phase + 2'd1 : enc_phase - 2'd1;
      ev = random_event(CMD_ENCODER);
      ev.enc_a = {enc_phase[1], enc_phase[1] ^ enc_phase[0]};
      ev.enc_b = garble ? ev.enc_a ^ 2'($urandom_range(1, 3)) : ev.enc_a;
      send_event(ev);
   endtask

   // Both channels are sampled here so that each accepted item is noted before
   // any result in the same cycle is checked.
   always @(posedge clock) begin : transfer_monitor
      panel_event_type seen_ev;
      led_readout_type seen_out;
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            seen_ev.command = req_command;
            seen_ev.steps = req_step_switches;
            seen_ev.side = req_side_switch;
            seen_ev.play = req_play_switch;
            seen_ev.enc_a = req_encoder_ab;
            seen_ev.enc_b = req_encoder_ab_again;
            seen_ev.pot_raw = req_pot_raw;
            seen_ev.note = req_bus_byte;
            sb.note_command(seen_ev);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen_out.read_data = rsp_read_data;
            seen_out.step_leds = rsp_step_leds;
            seen_out.upper_side_led = rsp_upper_side_led;
            seen_out.stopped_led = rsp_stopped_led;
            seen_out.bus_error = rsp_bus_error;
            sb.check_readout(seen_out);
         end
      end
   end

   // Result side: a drawn stall before each transfer, plus two long hold-offs
   // that let the block fill up and push back on the input.
   initial begin : result_taker
      int gap;
      int taken;
      int rsp_burst;
      taken = 0;
      rsp_burst = 0;
      forever begin
         gap = next_gap(rsp_burst);
         if (taken == 150 || taken == 600) gap = LONG_HOLD;
         repeat (gap) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || !(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         taken++;
      end
   end

   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Run timed out with %0d results still due.", sb.due_count());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : stimulus
      panel_event_type ev;
      panel_event_type held;
      int              random_start;
      int              n;
      bit [3:0]        level;
      bit              steady;
      bit              up;
      sb = new;
      read_pos = 0;
      send_burst = 0;
      events_sent = 0;
      halt_wanted = 1'b0;
      enc_phase = 2'd0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_SWITCH;
      req_step_switches = 8'd0;
      req_side_switch = 1'b0;
      req_play_switch = 1'b0;
      req_encoder_ab = 2'd0;
      req_encoder_ab_again = 2'd0;
      req_pot_raw = 8'd0;
      req_bus_byte = 8'd0;
      rsp_stall = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. A read next before any read start returns the zero snapshot.
      send_event(random_event(CMD_READ_NEXT));
      ev = random_event(CMD_WRITE);
      ev.note = 8'd0;
      send_event(ev);
      ev = random_event(CMD_SWITCH);
      ev.steps = 8'hFF;
      ev.side = 1'b1;
      ev.play = 1'b1;
      send_event(ev);
      // A second change while the debounce is pending is ignored.
      ev = random_event(CMD_SWITCH);
      ev.steps = 8'h00;
      send_event(ev);
      ev = random_event(CMD_EXPIRY);
      ev.steps = 8'hFF;
      ev.side = 1'b1;
      ev.play = 1'b1;
      send_event(ev);
      // An expiry with nothing pending does nothing.
      send_event(random_event(CMD_EXPIRY));
      ev = random_event(CMD_SWITCH);
      ev.steps = 8'h00;
      ev.side = 1'b0;
      ev.play = 1'b1;
      send_event(ev);
      ev = random_event(CMD_EXPIRY);
      ev.steps = 8'h01;
      ev.side = 1'b1;
      ev.play = 1'b1;
      send_event(ev);
      ev = random_event(CMD_WRITE);
      ev.note = 8'd8;
      send_event(ev);
      ev = random_event(CMD_WRITE);
      ev.note = 8'd15;
      send_event(ev);
      ev = random_event(CMD_WRITE);
      ev.note = 8'hFF;
      send_event(ev);
      // Turning down from track zero holds the track at its lower limit.
      turn_encoder(1'b0, 1'b0);
      turn_encoder(1'b1, 1'b1);
      repeat (6) turn_encoder(1'b1, 1'b0);
      ev = random_event(CMD_POT);
      ev.pot_raw = 8'hFF;
      send_event(ev);
      ev = random_event(CMD_POT);
      ev.pot_raw = 8'h00;
      send_event(ev);
      send_event(random_event(CMD_READ_START));
      send_event(random_event(CMD_READ_NEXT));
      send_event(random_event(CMD_SPARE));

      random_start = events_sent;
      while (events_sent - random_start < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               ev = random_event(CMD_SWITCH);
               if ($urandom_range(0, 1)) ev.steps = 8'd1 << $urandom_range(0, 7);
               else if ($urandom_range(0, 7) == 0) ev.steps = 8'd0;
               held = ev;
               send_event(ev);
               if ($urandom_range(0, 3) == 0) send_event(random_event(CMD_SWITCH));
               ev = random_event(CMD_EXPIRY);
               if ($urandom_range(0, 3) != 0) ev.steps = held.steps;
               if ($urandom_range(0, 3) != 0) ev.side = held.side;
               if ($urandom_range(0, 3) != 0) ev.play = held.play;
               send_event(ev);
               if ($urandom_range(0, 5) == 0) send_event(random_event(CMD_EXPIRY));
            end
            2, 3: begin
               up = 1'($urandom());
               repeat ($urandom_range(2, 24)) turn_encoder(up, $urandom_range(0, 7) == 0);
            end
            4, 5: begin
               n = $urandom_range(2, 20);
               level = 4'($urandom());
               steady = 1'($urandom());
               repeat (n) begin
                  ev = random_event(CMD_POT);
                  if (steady) ev.pot_raw[7:4] = level;
                  send_event(ev);
               end
            end
            6, 7: begin
               send_event(random_event(CMD_READ_START));
               repeat ($urandom_range(0, 6)) send_event(random_event(CMD_READ_NEXT));
            end
            8: begin
               ev = random_event(CMD_WRITE);
               if ($urandom_range(0, 3) != 0) ev.note = 8'($urandom_range(0, 15));
               send_event(ev);
            end
            default: send_event(random_event(3'($urandom_range(0, 7))));
         endcase
      end

      // Reading past the last snapshot byte halts the block; every command
      // after that must leave the frozen state alone.
      halt_wanted = 1'b1;
      send_event(random_event(CMD_READ_START));
      repeat (SNAP_BYTES) send_event(random_event(CMD_READ_NEXT));
      for (int i = 0; i < 8; i++) send_event(random_event(3'(i)));

      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.due_count() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d transfers: switch %0d, expiry %0d, encoder %0d, pot %0d, ",
               events_sent, sb.seen[CMD_SWITCH], sb.seen[CMD_EXPIRY], sb.seen[CMD_ENCODER],
               sb.seen[CMD_POT]);
      $display("read start %0d, read next %0d, write %0d, spare %0d; %0d results %s",
               sb.seen[CMD_READ_START], sb.seen[CMD_READ_NEXT], sb.seen[CMD_WRITE],
               sb.seen[CMD_SPARE], sb.compared,
               $sformatf("compared, %0d track limit hits.", sb.clamp_hits));
      if (sb.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
